FILE: rtl/neuron_mac_momentum_update_macros.svh
// Assertion macros shared by the neuron RTL.
`ifndef NEURON_MAC_MOMENTUM_UPDATE_MACROS_SVH
`define NEURON_MAC_MOMENTUM_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define NMM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("neuron assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define NMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("neuron assertion failed");
`else
`define NMM_ASSERT_IMPLY(label, ante, cons)
`define NMM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/nmm_pkg.sv
// Package with types, constants and fixed-point helpers for the neuron.
`default_nettype none
package nmm_pkg;

    localparam int MAX_INPUTS = 256;
    localparam int ADDR_W     = $clog2(MAX_INPUTS);
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int MUL_W      = DATA_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int RATE_W     = 17;
    localparam int ACT_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [RATE_W-1:0] LR_RESET     = RATE_W'(6554);
    localparam logic [RATE_W-1:0] MOM_RESET    = '0;
    localparam logic [ACT_W-1:0]  ACTIVE_RESET = ACT_W'(256);

    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] FIX_ONE  = DATA_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        FUNC_LOAD_W = 3'd0,
        FUNC_LOAD_B = 3'd1,
        FUNC_ACC    = 3'd2,
        FUNC_ADD_B  = 3'd3,
        FUNC_ERROR  = 3'd4,
        FUNC_UPD_W  = 3'd5,
        FUNC_UPD_B  = 3'd6
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LR     = 2'd0,
        CFG_MOM    = 2'd1,
        CFG_ACTIVE = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]               func;
        logic [ADDR_W-1:0]        index;
        logic signed [DATA_W-1:0] operand;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] neuron_value;
        logic signed [DATA_W-1:0] error_delta;
        logic signed [DATA_W-1:0] weight_now;
        logic                     size_mismatch;
    } result_t;

    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
        logic signed [DATA_W-1:0] weight;
        logic signed [DATA_W-1:0] momentum;
    } store_wr_t;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? DATA_MIN : DATA_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? DATA_MIN : DATA_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    // Arithmetic shift floors the product; the result then saturates.
    function automatic logic signed [DATA_W-1:0] fix_scale(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] sh;
        sh = p >>> FRAC_BITS;
        if ((&sh[PROD_W-1:DATA_W-1]) || !(|sh[PROD_W-1:DATA_W-1])) begin
            return sh[DATA_W-1:0];
        end
        return sh[PROD_W-1] ? DATA_MIN : DATA_MAX;
    endfunction

    function automatic logic signed [MUL_W-1:0] sx_mul(input logic signed [DATA_W-1:0] a);
        return {a[DATA_W-1], a};
    endfunction

    function automatic logic signed [MUL_W-1:0] zx_mul(input logic [RATE_W-1:0] a);
        return {{(MUL_W-RATE_W){1'b0}}, a};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/nmm_store.sv
// Weight and momentum memories with a registered read.
`default_nettype none
module nmm_store
    import nmm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [ADDR_W-1:0]        rd_addr,
    input  wire store_wr_t                wr,
    output logic signed [DATA_W-1:0]      rd_weight,
    output logic signed [DATA_W-1:0]      rd_momentum
);

    logic signed [DATA_W-1:0] weight_mem   [MAX_INPUTS];
    logic signed [DATA_W-1:0] momentum_mem [MAX_INPUTS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            weight_mem[wr.addr]   <= wr.weight;
            momentum_mem[wr.addr] <= wr.momentum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_weight   <= weight_mem[rd_addr];
            rd_momentum <= momentum_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/nmm_fmul.sv
// Shared fixed-point multiplier: registered product, floor shift and saturation.
`default_nettype none
module nmm_fmul
    import nmm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic signed [MUL_W-1:0] a,
    input  wire logic signed [MUL_W-1:0] b,
    output logic signed [DATA_W-1:0]     res
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign res = fix_scale(prod_reg);

endmodule
`default_nettype wire

FILE: rtl/neuron_mac_momentum_update.sv
// Neuron with weight and momentum stores trained by SGD with momentum (top level).
// Each transfer steps through READ and DONE; accumulate and bias update pass MUL1 on the way,
// error passes MUL1 and MUL2, and weight update passes MUL1, MUL2, MUL3 and WRITE.
// One item at a time, set by the shared multiplier chain and the weight store read-modify-write:
// the next transfer is taken in the cycle after the result is registered.
// Reset clears control, configuration and neuron registers; the stores are not cleared.
`default_nettype none
module neuron_mac_momentum_update
    import nmm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "neuron_mac_momentum_update_macros.svh"

    state_t state_reg, state_next;
    item_t  item_reg;

    logic [RATE_W-1:0] lr_reg, mom_reg;
    logic [ACT_W-1:0]  active_reg;

    logic signed [DATA_W-1:0] bias_reg, value_reg, error_reg, acc_reg;
    logic signed [DATA_W-1:0] wnow_reg, tmp_reg, step_reg;
    logic                     mismatch_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    logic                     accept;
    logic                     out_fire;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [DATA_W-1:0] mul_res;
    logic signed [DATA_W-1:0] rd_weight, rd_momentum;
    store_wr_t                wr;

    logic signed [DATA_W-1:0] one_minus, err_diff, acc_base, acc_sum, new_weight;
    logic                     count_match;

    assign accept    = item_valid && !item_stall;
    assign out_fire  = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
    assign cfg_ready = 1'b1;

    assign one_minus   = sat_sub(FIX_ONE, value_reg);
    assign err_diff    = sat_sub(item_reg.operand, value_reg);
    assign acc_base    = (item_reg.index == '0) ? '0 : acc_reg;
    assign acc_sum     = sat_add(acc_base, mul_res);
    assign count_match = (ACT_W'(item_reg.index) + ACT_W'(1)) == active_reg;
    assign new_weight  = sat_add(wnow_reg, step_reg);

    nmm_store u_store (
        .clk         (clk),
        .rd_en       (accept),
        .rd_addr     (item.index),
        .wr          (wr),
        .rd_weight   (rd_weight),
        .rd_momentum (rd_momentum)
    );

    nmm_fmul u_fmul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .res (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state, operand selection for the multiplier and store writes.
    always_comb
    begin
        state_next  = state_reg;
        item_stall  = (state_reg != ST_IDLE);
        mul_a       = '0;
        mul_b       = '0;
        wr.en       = 1'b0;
        wr.addr     = item_reg.index;
        wr.weight   = new_weight;
        wr.momentum = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
                unique case (item_reg.func)
                    FUNC_LOAD_W:
                    begin
                        wr.en       = 1'b1;
                        wr.weight   = item_reg.operand;
                        wr.momentum = '0;
                    end
                    FUNC_ACC:
                    begin
                        mul_a      = sx_mul(rd_weight);
                        mul_b      = sx_mul(item_reg.operand);
                        state_next = ST_MUL1;
                    end
                    FUNC_ERROR:
                    begin
                        mul_a      = sx_mul(err_diff);
                        mul_b      = sx_mul(value_reg);
                        state_next = ST_MUL1;
                    end
                    FUNC_UPD_W:
                    begin
                        mul_a      = sx_mul(rd_momentum);
                        mul_b      = zx_mul(mom_reg);
                        state_next = ST_MUL1;
                    end
                    FUNC_UPD_B:
                    begin
                        mul_a      = zx_mul(lr_reg);
                        mul_b      = sx_mul(error_reg);
                        state_next = ST_MUL1;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MUL1:
            begin
                state_next = ST_DONE;
                if (item_reg.func == FUNC_ERROR)
                begin
                    mul_a      = sx_mul(mul_res);
                    mul_b      = sx_mul(one_minus);
                    state_next = ST_MUL2;
                end
                else if (item_reg.func == FUNC_UPD_W)
                begin
                    mul_a      = sx_mul(item_reg.operand);
                    mul_b      = sx_mul(error_reg);
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                state_next = ST_DONE;
                if (item_reg.func == FUNC_UPD_W)
                begin
                    mul_a      = sx_mul(mul_res);
                    mul_b      = zx_mul(lr_reg);
                    state_next = ST_MUL3;
                end
            end
            ST_MUL3:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                wr.en      = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg     <= LR_RESET;
            mom_reg    <= MOM_RESET;
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LR:     lr_reg     <= cfg_data[RATE_W-1:0];
                CFG_MOM:    mom_reg    <= cfg_data[RATE_W-1:0];
                CFG_ACTIVE: active_reg <= cfg_data[ACT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Neuron state registers, updated by the sequencer step that produces them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg     <= '0;
            value_reg    <= '0;
            error_reg    <= '0;
            acc_reg      <= '0;
            mismatch_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_READ)
            begin
                mismatch_reg <= 1'b0;
                if (item_reg.func == FUNC_LOAD_B)
                begin
                    bias_reg <= item_reg.operand;
                end
                if (item_reg.func == FUNC_ADD_B)
                begin
                    value_reg <= sat_add(value_reg, bias_reg);
                end
            end
            if (state_reg == ST_MUL1)
            begin
                if (item_reg.func == FUNC_ACC)
                begin
                    acc_reg <= acc_sum;
                    if (item_reg.last)
                    begin
                        if (count_match)
                        begin
                            value_reg <= acc_sum;
                        end
                        else
                        begin
                            mismatch_reg <= 1'b1;
                        end
                    end
                end
                if (item_reg.func == FUNC_UPD_B)
                begin
                    bias_reg <= sat_add(bias_reg, mul_res);
                end
            end
            if ((state_reg == ST_MUL2) && (item_reg.func == FUNC_ERROR))
            begin
                error_reg <= mul_res;
            end
        end
    end

    // Working registers of the weight update and the weight shown in the result.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            wnow_reg <= (item_reg.func == FUNC_LOAD_W) ? item_reg.operand : rd_weight;
        end
        if (state_reg == ST_MUL1)
        begin
            tmp_reg <= mul_res;
        end
        if (state_reg == ST_MUL3)
        begin
            step_reg <= sat_add(mul_res, tmp_reg);
        end
        if (state_reg == ST_WRITE)
        begin
            wnow_reg <= new_weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            result_reg.neuron_value  <= value_reg;
            result_reg.error_delta   <= error_reg;
            result_reg.weight_now    <= wnow_reg;
            result_reg.size_mismatch <= mismatch_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `NMM_ASSERT_NEXT(a_accept_reads, item_valid && !item_stall, state_reg == ST_READ)
    `NMM_ASSERT_IMPLY(a_result_from_done, $rose(result_valid_reg), $past(state_reg) == ST_DONE)
    `NMM_ASSERT_IMPLY(a_write_after_mul, state_reg == ST_WRITE, $past(state_reg) == ST_MUL3)

endmodule
`default_nettype wire

FILE: sim/neuron_checker.sv
// Checker for the neuron: predicts each result from the observed transfers and compares it.
module neuron_checker
    import nmm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire logic                  item_stall,
    input  wire item_t                 item,
    input  wire logic                  result_valid,
    input  wire logic                  result_stall,
    input  wire result_t               result,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         failures,
    output int                         outstanding
);

    // Predicted neuron state and configuration.
    logic signed [DATA_W-1:0] weight_mem [MAX_INPUTS];
    logic signed [DATA_W-1:0] step_mem [MAX_INPUTS];
    logic signed [DATA_W-1:0] bias_q;
    logic signed [DATA_W-1:0] value_q;
    logic signed [DATA_W-1:0] delta_q;
    logic signed [DATA_W-1:0] dot_q;
    logic [RATE_W-1:0]        rate_q;
    logic [RATE_W-1:0]        mom_q;
    logic [ACT_W-1:0]         active_q;

    result_t expected_results [$];

    function automatic logic signed [DATA_W-1:0] clamp(input longint v);
        if (v > longint'(DATA_MAX))
        begin
            return DATA_MAX;
        end
        if (v < longint'(DATA_MIN))
        begin
            return DATA_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // Exact product, floored by the arithmetic shift, then clamped.
    function automatic logic signed [DATA_W-1:0] qmul(input longint a, input longint b);
        return clamp((a * b) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [DATA_W-1:0] qadd(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return clamp(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [DATA_W-1:0] qsub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return clamp(longint'(a) - longint'(b));
    endfunction

    function automatic result_t neuron_step(input item_t it);
        result_t                  r;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] m;
        logic signed [DATA_W-1:0] op;
        logic signed [DATA_W-1:0] ramp;
        logic signed [DATA_W-1:0] prod;
        logic signed [DATA_W-1:0] grad;
        logic signed [DATA_W-1:0] stp;
        w = weight_mem[it.index];
        m = step_mem[it.index];
        op = it.operand;
        r.size_mismatch = 1'b0;
        case (it.func)
            FUNC_LOAD_W:
            begin
                weight_mem[it.index] = op;
                step_mem[it.index] = '0;
            end
            FUNC_LOAD_B: bias_q = op;
            FUNC_ACC:
            begin
                if (it.index == '0)
                begin
                    dot_q = '0;
                end
                dot_q = qadd(dot_q, qmul(w, op));
                if (it.last)
                begin
                    // A run only commits when it ends on the last active weight.
                    if (active_q != '0 && ACT_W'(it.index) == active_q - 1'b1)
                    begin
                        value_q = dot_q;
                    end
                    else
                    begin
                        r.size_mismatch = 1'b1;
                    end
                end
            end
            FUNC_ADD_B: value_q = qadd(value_q, bias_q);
            FUNC_ERROR:
            begin
                ramp = qsub(FIX_ONE, value_q);
                prod = qmul(qsub(op, value_q), value_q);
                delta_q = qmul(prod, ramp);
            end
            FUNC_UPD_W:
            begin
                grad = qmul(qmul(op, delta_q), rate_q);
                stp = qadd(grad, qmul(m, mom_q));
                weight_mem[it.index] = qadd(w, stp);
                step_mem[it.index] = stp;
            end
            FUNC_UPD_B: bias_q = qadd(bias_q, qmul(rate_q, delta_q));
            default: ;
        endcase
        r.neuron_value = value_q;
        r.error_delta = delta_q;
        r.weight_now = weight_mem[it.index];
        return r;
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            rate_q = LR_RESET;
            mom_q = MOM_RESET;
            active_q = ACTIVE_RESET;
            bias_q = '0;
            value_q = '0;
            delta_q = '0;
            dot_q = '0;
            expected_results.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            // The result leaving at this edge always belongs to an earlier transfer.
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report("result transfer with nothing expected");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.neuron_value !== want.neuron_value)
                    begin
                        report($sformatf("neuron_value: expected %h, got %h",
                                         want.neuron_value, result.neuron_value));
                    end
                    if (result.error_delta !== want.error_delta)
                    begin
                        report($sformatf("error_delta: expected %h, got %h",
                                         want.error_delta, result.error_delta));
                    end
                    if (result.weight_now !== want.weight_now)
                    begin
                        report($sformatf("weight_now: expected %h, got %h",
                                         want.weight_now, result.weight_now));
                    end
                    if (result.size_mismatch !== want.size_mismatch)
                    begin
                        report($sformatf("size_mismatch: expected %b, got %b",
                                         want.size_mismatch, result.size_mismatch));
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LR:     rate_q = cfg_data[RATE_W-1:0];
                    CFG_MOM:    mom_q = cfg_data[RATE_W-1:0];
                    CFG_ACTIVE: active_q = cfg_data[ACT_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                expected_results.push_back(neuron_step(item));
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// Top of the neuron testbench: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;
    import nmm_pkg::*;

    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam int TARGET_ITEMS = 650;
    localparam int N_FIXED = 6;
    localparam logic signed [DATA_W-1:0] HALF = 32'sh0000_8000;

    // Settings with the extremes, visited before the random ones.
    logic [CFG_DATA_W-1:0] fixed_lr [N_FIXED]  = '{0, 65536, 131071, 6554, 1, 65536};
    logic [CFG_DATA_W-1:0] fixed_mom [N_FIXED] = '{0, 65536, 131071, 32768, 65536, 0};
    logic [CFG_DATA_W-1:0] fixed_act [N_FIXED] = '{1, 4, 0, 511, 256, 3};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    failures;
    int                    outstanding;

    int               sent_items;
    logic [ACT_W-1:0] active_now;
    bit               loaded [MAX_INPUTS];
    int               loaded_list [$];
    bit               no_gaps;
    bit               calm = 1'b0;
    int               stall_left = 0;

    neuron_mac_momentum_update DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    neuron_checker prediction_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver stalls: mostly short, a few long, with calm stretches where no new stall starts.
    always @(posedge clk or negedge rst_n)
    begin
        int r;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
            calm <= 1'b0;
        end
        else
        begin
            if ($urandom_range(149) == 0)
            begin
                calm <= ~calm;
            end
            r = $urandom_range(99);
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (calm || r < 65)
            begin
                result_stall <= 1'b0;
            end
            else if (r < 95)
            begin
                result_stall <= 1'b1;
                stall_left <= $urandom_range(2);
            end
            else
            begin
                result_stall <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
        begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Mostly values around the unit range, with some full-width words and extremes.
    function automatic logic signed [DATA_W-1:0] rand_q();
        int r;
        r = $urandom_range(99);
        if (r < 65)
        begin
            return int'($urandom_range(262144)) - 131072;
        end
        if (r < 80)
        begin
            return $urandom_range(65536);
        end
        if (r < 94)
        begin
            return $urandom;
        end
        case ($urandom_range(4))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return FIX_ONE;
            3: return '0;
            default: return -1;
        endcase
    endfunction

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Valid is left high after the transfer so that back-to-back items need no toggle.
    task automatic send_item(
        input logic [2:0]               code,
        input logic [ADDR_W-1:0]        idx,
        input logic signed [DATA_W-1:0] value,
        input logic                     fin
    );
        int gap;
        gap = pick_gap();
        if ($urandom_range(24) == 0)
        begin
            wait_drained();
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{func: code, index: idx, operand: value, last: fin};
        do @(posedge clk); while (item_stall);
        sent_items++;
    endtask

    task automatic mark_loaded(input int idx);
        if (!loaded[idx])
        begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    task automatic load_weight(input int idx, input logic signed [DATA_W-1:0] value);
        send_item(FUNC_LOAD_W, idx, value, 1'b0);
        mark_loaded(idx);
    endtask

    // Any operation, including the unused code, on a weight that has been written.
    task automatic maybe_noise();
        logic [2:0]        code;
        logic [ADDR_W-1:0] idx;
        if ($urandom_range(9) == 0)
        begin
            code = $urandom_range(7);
            if (code == FUNC_LOAD_W)
            begin
                idx = $urandom_range(MAX_INPUTS - 1);
                mark_loaded(idx);
            end
            else
            begin
                idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
            end
            send_item(code, idx, rand_q(), $urandom_range(1));
        end
    endtask

    task automatic cfg_beat(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setting(
        input logic [CFG_DATA_W-1:0] lr,
        input logic [CFG_DATA_W-1:0] mom,
        input logic [CFG_DATA_W-1:0] act
    );
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_beat(CFG_LR, lr);
        cfg_beat(CFG_MOM, mom);
        cfg_beat(CFG_ACTIVE, act);
        cfg_valid <= 1'b0;
        active_now = act[ACT_W-1:0];
    endtask

    // One training step: load, dot product, bias, error, weight and bias updates.
    task automatic train_run();
        int run [$];
        int n;
        int kind;
        int stop_at;
        no_gaps = ($urandom_range(4) == 0);
        if (active_now >= 1 && active_now <= 12)
        begin
            for (int i = 0; i < active_now; i++)
            begin
                run.push_back(i);
            end
        end
        else
        begin
            // Long runs are cut short: a few leading weights, then the closing one.
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
            begin
                run.push_back(i);
            end
            if (active_now >= 1 && active_now <= MAX_INPUTS)
            begin
                run.push_back(active_now - 1);
            end
            else
            begin
                run.push_back($urandom_range(MAX_INPUTS - 1));
            end
        end
        foreach (run[i])
        begin
            if (!loaded[run[i]] || $urandom_range(1))
            begin
                maybe_noise();
                load_weight(run[i], rand_q());
            end
        end
        if ($urandom_range(9) < 6)
        begin
            send_item(FUNC_LOAD_B, run[0], rand_q(), $urandom_range(1));
        end
        // Now and then a broken run: the last mark comes early or never.
        kind = $urandom_range(9);
        stop_at = (kind == 0) ? $urandom_range(run.size() - 1) : run.size() - 1;
        foreach (run[i])
        begin
            if (i <= stop_at)
            begin
                maybe_noise();
                send_item(FUNC_ACC, run[i], rand_q(), (i == stop_at) && kind != 1);
            end
        end
        if ($urandom_range(3) != 0)
        begin
            send_item(FUNC_ADD_B, run[0], rand_q(), $urandom_range(1));
        end
        maybe_noise();
        send_item(FUNC_ERROR, run[0],
                  ($urandom_range(3) != 0) ? $urandom_range(65536) : rand_q(), 1'b0);
        foreach (run[i])
        begin
            maybe_noise();
            send_item(FUNC_UPD_W, run[i], rand_q(), $urandom_range(1));
        end
        send_item(FUNC_UPD_B, run[0], rand_q(), $urandom_range(1));
    endtask

    initial
    begin
        int                    phase;
        int                    waited;
        int                    r;
        logic [CFG_DATA_W-1:0] act;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LR;
        cfg_data = '0;
        sent_items = 0;
        no_gaps = 1'b0;
        active_now = ACTIVE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset settings, where all 256 weights are active.
        load_weight(0, DATA_MAX);
        load_weight(MAX_INPUTS - 1, DATA_MIN);
        load_weight(1, FIX_ONE);
        load_weight(2, -HALF);
        send_item(FUNC_ACC, 0, DATA_MAX, 1'b0);
        send_item(FUNC_ACC, 1, DATA_MAX, 1'b0);
        send_item(FUNC_ACC, MAX_INPUTS - 1, DATA_MAX, 1'b1);
        send_item(FUNC_ACC, 0, FIX_ONE, 1'b1);
        send_item(FUNC_LOAD_B, 2, DATA_MAX, 1'b0);
        send_item(FUNC_ADD_B, 2, '0, 1'b0);
        send_item(FUNC_ADD_B, 2, '0, 1'b1);
        send_item(FUNC_ERROR, 0, DATA_MIN, 1'b0);
        send_item(FUNC_LOAD_B, 1, DATA_MIN, 1'b0);
        send_item(FUNC_UPD_B, 1, '0, 1'b0);
        send_item(FUNC_ACC, 0, '0, 1'b0);
        send_item(FUNC_ACC, 1, HALF, 1'b0);
        send_item(FUNC_ACC, MAX_INPUTS - 1, '0, 1'b1);
        send_item(FUNC_ERROR, 1, FIX_ONE, 1'b0);
        send_item(FUNC_UPD_W, 1, DATA_MAX, 1'b0);
        send_item(FUNC_UPD_W, MAX_INPUTS - 1, DATA_MIN, 1'b1);
        send_item(FUNC_UPD_B, 0, FIX_ONE, 1'b0);
        send_item(FUNC_UNUSED, 2, -1, 1'b1);
        load_weight(1, HALF);
        send_item(FUNC_UPD_W, 1, FIX_ONE, 1'b0);

        phase = 0;
        while (sent_items < TARGET_ITEMS)
        begin
            if (phase < N_FIXED)
            begin
                apply_setting(fixed_lr[phase], fixed_mom[phase], fixed_act[phase]);
            end
            else
            begin
                r = $urandom_range(9);
                if (r < 7)
                begin
                    act = $urandom_range(1, 10);
                end
                else if (r < 8)
                begin
                    act = $urandom_range(11, MAX_INPUTS);
                end
                else
                begin
                    act = $urandom_range(511);
                end
                // Bits above the active count field are not part of the register.
                if ($urandom_range(3) == 0)
                begin
                    act[CFG_DATA_W-1:ACT_W] = $urandom;
                end
                apply_setting($urandom_range(65536), $urandom_range(65536), act);
            end
            phase++;
            repeat ($urandom_range(2, 4)) train_run();
        end

        item_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (outstanding != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (failures == 0 && outstanding == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
